### src/h2fps_pkg.sv
// Shared types and constants for the HTTP/2 frame preflight scanner.
package h2fps_pkg;

	localparam logic [7:0] TYPE_HEADERS      = 8'h01;
	localparam logic [7:0] TYPE_CONTINUATION = 8'h09;
	localparam logic [3:0] HDR_LAST_POS      = 4'd8;
	localparam logic [6:0] SID_TOP_MASK      = 7'h7f;

	localparam logic CFG_HEADER_BUDGET   = 1'b0;
	localparam logic CFG_STREAM_ID_LIMIT = 1'b1;

	typedef struct packed {
		logic [31:0] header_budget;
		logic [30:0] stream_id_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0] frame_total;
		logic [30:0] highest_stream_id;
		logic [31:0] header_byte_total;
		logic        malformed_flag;
		logic        budget_exceeded_flag;
		logic        stream_anomaly_flag;
	} summary_t;

endpackage

### src/http2_frame_preflight_scanner.sv
// A request is registered at the input, scanned from that register, and the summary of an
// ending request is registered onto the output when that request leaves the input register.
// Throughput: one byte request per cycle; only an ending request waiting on a stalled
// output holds the input, and the single scan state update per byte sets that rate.
// Reset clears the scan state, both pipeline valids and loads the register defaults.
module http2_frame_preflight_scanner #(
	parameter logic [31:0] BUDGET_RESET = 32'd65536,
	parameter logic [30:0] SID_LIMIT_RESET = 31'h7fff_ffff
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        has_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] frame_total,
	output logic [30:0] highest_stream_id,
	output logic [31:0] header_byte_total,
	output logic        malformed_flag,
	output logic        budget_exceeded_flag,
	output logic        stream_anomaly_flag
);
	import h2fps_pkg::*;

	cfg_t     cfg_q;
	logic     valid_s1;
	logic [7:0] byte_s1;
	logic     has_s1;
	logic     end_s1;
	logic     adv;
	logic     out_valid_q;
	summary_t sum_n;
	summary_t sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_budget   <= BUDGET_RESET;
			cfg_q.stream_id_limit <= SID_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HEADER_BUDGET:   cfg_q.header_budget <= cfg_data;
				CFG_STREAM_ID_LIMIT: cfg_q.stream_id_limit <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && !(end_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_value;
			has_s1  <= has_byte;
			end_s1  <= end_of_buffer;
		end
	end

	h2fps_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.byte_value    (byte_s1),
		.has_byte      (has_s1),
		.end_of_buffer (end_s1),
		.cfg           (cfg_q),
		.summary       (sum_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			sum_q <= sum_n;
		end
	end

	assign out_valid            = out_valid_q;
	assign frame_total          = sum_q.frame_total;
	assign highest_stream_id    = sum_q.highest_stream_id;
	assign header_byte_total    = sum_q.header_byte_total;
	assign malformed_flag       = sum_q.malformed_flag;
	assign budget_exceeded_flag = sum_q.budget_exceeded_flag;
	assign stream_anomaly_flag  = sum_q.stream_anomaly_flag;

`ifndef NO_ASSERTIONS
	a_end_gives_summary: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> out_valid)
		else $error("ending request did not produce a summary");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && end_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked summary");

	a_no_frames_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_total == 32'd0 |-> highest_stream_id == 31'd0)
		else $error("stream id reported without any counted frame");
`endif

endmodule

### src/h2fps_scan.sv
// Byte-at-a-time frame header parser with per-buffer statistics.
module h2fps_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_value,
	input  logic              has_byte,
	input  logic              end_of_buffer,
	input  h2fps_pkg::cfg_t   cfg,
	output h2fps_pkg::summary_t summary
);
	import h2fps_pkg::*;

	logic [3:0]  pos_q;
	logic [23:0] len_q;
	logic [7:0]  typ_q;
	logic [30:0] sid_q;
	logic [23:0] rem_q;
	logic [31:0] cnt_q;
	logic [30:0] maxid_q;
	logic [31:0] hsum_q;
	logic        bflag_q;
	logic        aflag_q;

	logic [3:0]  pos_n;
	logic [23:0] len_n;
	logic [7:0]  typ_n;
	logic [30:0] sid_n;
	logic [23:0] rem_n;
	logic [31:0] cnt_n;
	logic [30:0] maxid_n;
	logic [31:0] hsum_n;
	logic        bflag_n;
	logic        aflag_n;
	logic        count;
	logic [32:0] sum_wide;

	always_comb begin
		pos_n    = pos_q;
		len_n    = len_q;
		typ_n    = typ_q;
		sid_n    = sid_q;
		rem_n    = rem_q;
		cnt_n    = cnt_q;
		maxid_n  = maxid_q;
		hsum_n   = hsum_q;
		bflag_n  = bflag_q;
		aflag_n  = aflag_q;
		count    = 1'b0;
		sum_wide = {1'b0, hsum_q} + {9'd0, len_q};
		if (has_byte) begin
			if (rem_q != 24'd0) begin
				rem_n = rem_q - 24'd1;
				count = (rem_q == 24'd1);
			end else begin
				unique case (pos_q)
					4'd0: len_n = {byte_value, 16'd0};
					4'd1: len_n[15:8] = byte_value;
					4'd2: len_n[7:0] = byte_value;
					4'd3: typ_n = byte_value;
					4'd4: ;
					4'd5: sid_n = {byte_value[6:0] & SID_TOP_MASK, 24'd0};
					4'd6: sid_n[23:16] = byte_value;
					4'd7: sid_n[15:8] = byte_value;
					default: sid_n[7:0] = byte_value;
				endcase
				pos_n = pos_q + 4'd1;
				if (pos_q >= HDR_LAST_POS) begin
					pos_n = 4'd0;
					if (len_n == 24'd0) begin
						count = 1'b1;
					end else begin
						rem_n = len_n;
					end
				end
			end
		end
		if (count) begin
			if (cnt_q != 32'hffff_ffff) begin
				cnt_n = cnt_q + 32'd1;
			end
			if (sid_n > maxid_q) begin
				maxid_n = sid_n;
			end
			if (sid_n > cfg.stream_id_limit) begin
				aflag_n = 1'b1;
			end
			if (typ_n == TYPE_HEADERS || typ_n == TYPE_CONTINUATION) begin
				hsum_n = sum_wide[32] ? 32'hffff_ffff : sum_wide[31:0];
				if (hsum_n > cfg.header_budget) begin
					bflag_n = 1'b1;
				end
			end
		end
		summary.frame_total          = cnt_n;
		summary.highest_stream_id    = maxid_n;
		summary.header_byte_total    = hsum_n;
		summary.malformed_flag       = (pos_n != 4'd0) || (rem_n != 24'd0);
		summary.budget_exceeded_flag = bflag_n;
		summary.stream_anomaly_flag  = aflag_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			typ_q   <= '0;
			sid_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			maxid_q <= '0;
			hsum_q  <= '0;
			bflag_q <= 1'b0;
			aflag_q <= 1'b0;
		end else if (step) begin
			if (end_of_buffer) begin
				pos_q   <= '0;
				len_q   <= '0;
				typ_q   <= '0;
				sid_q   <= '0;
				rem_q   <= '0;
				cnt_q   <= '0;
				maxid_q <= '0;
				hsum_q  <= '0;
				bflag_q <= 1'b0;
				aflag_q <= 1'b0;
			end else begin
				pos_q   <= pos_n;
				len_q   <= len_n;
				typ_q   <= typ_n;
				sid_q   <= sid_n;
				rem_q   <= rem_n;
				cnt_q   <= cnt_n;
				maxid_q <= maxid_n;
				hsum_q  <= hsum_n;
				bflag_q <= bflag_n;
				aflag_q <= aflag_n;
			end
		end
	end

endmodule
